/* hdl/pfsa_pkg.sv */
// Shared constants and types for the page frame stack allocator.
`default_nettype none
package pfsa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int FRAME_BITS  = 44;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STATUS_W    = 3;
  localparam int IN_DATA_W   = ((FRAME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((FRAME_BITS + STATUS_W + 7) / 8) * 8;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_FREED     = 3'd2,
    ST_NEVER     = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    REG_FIRST_FRAME = 1'b0,
    REG_END_FRAME   = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

/* hdl/page_frame_stack_allocator_unit.sv */
// Top level of the page frame stack allocator: sequencer, recycle stack memory and output register.
`default_nettype none
// Channel   | Direction | Ports                          | Content
// ----------+-----------+--------------------------------+------------------------------------
// in_       | slave     | tvalid/tready/tdata/tuser      | tuser: op; tdata: frame_in
// out_      | master    | tvalid/tready/tdata            | tdata: frame_out, status
// cfg_      | write     | we/addr/wdata                  | 0: first_frame, 1: end_frame
//
// An allocate word that takes a fresh frame goes straight to the result state; when the recycle
// stack holds entries, a pop state reads the top entry first. A free of a frame that was never
// handed out goes straight to the result state. Any other free walks the stack one entry per
// cycle through the single memory read port, checks for a full stack and then pushes the frame;
// on an empty stack it pushes at once, and a duplicate ends the walk early.
// The unit holds in_tready low while a word is at work. A finished result sits in the output
// register, so the next word may be accepted while out_tready is low; a second result then
// waits in the sequencer.
// Reset is synchronous and active low; it empties the stack and clears both frame registers.
module page_frame_stack_allocator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pfsa_pkg::IN_DATA_W-1:0]    in_tdata,   // [43:0] frame_in, rest zero
  input  wire logic                              in_tuser,   // [0] op
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pfsa_pkg::OUT_DATA_W-1:0]        out_tdata,  // [43:0] frame_out, [46:44] status
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_addr,
  input  wire logic [pfsa_pkg::FRAME_BITS-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SCAN_TAIL,
    S_PUSH,
    S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  pfsa_pkg::cnt_t            cnt_r, cnt_nxt;
  pfsa_pkg::frame_t          next_frame_r, next_frame_nxt;
  pfsa_pkg::frame_t          end_frame_r, end_frame_nxt;
  pfsa_pkg::frame_t          frame_r, frame_nxt;
  pfsa_pkg::idx_t            idx_r, idx_nxt;
  logic                      cmp_v_r, cmp_v_nxt;
  pfsa_pkg::frame_t          res_frame_r, res_frame_nxt;
  pfsa_pkg::status_t         res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [pfsa_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Recycle stack memory: one write and one registered read per cycle.
  pfsa_pkg::frame_t          mem [pfsa_pkg::STACK_DEPTH];
  pfsa_pkg::frame_t          rd_data_r;
  logic                      mem_we;
  pfsa_pkg::idx_t            mem_waddr;
  pfsa_pkg::idx_t            mem_raddr;

  pfsa_pkg::frame_t          in_frame;
  pfsa_pkg::cnt_t            cnt_dec;
  pfsa_pkg::idx_t            top_idx;
  logic                      stack_full;
  logic                      hit;

  assign in_frame   = in_tdata[pfsa_pkg::FRAME_BITS-1:0];
  assign cnt_dec    = cnt_r - pfsa_pkg::CNT_W'(1);
  assign top_idx    = cnt_dec[pfsa_pkg::IDX_W-1:0];
  assign stack_full = (cnt_r >= pfsa_pkg::CNT_W'(pfsa_pkg::STACK_DEPTH));
  // The one comparator of the scan: last registered read against the freed frame.
  assign hit        = cmp_v_r && (rd_data_r == frame_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    next_frame_nxt = next_frame_r;
    end_frame_nxt  = end_frame_r;
    frame_nxt      = frame_r;
    idx_nxt        = idx_r;
    cmp_v_nxt      = 1'b0;
    res_frame_nxt  = res_frame_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[pfsa_pkg::IDX_W-1:0];
    mem_raddr      = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          frame_nxt     = in_frame;
          idx_nxt       = '0;
          res_frame_nxt = '0;
          if (pfsa_pkg::op_t'(in_tuser) == pfsa_pkg::OP_ALLOC) begin
            if (cnt_r != '0) begin
              // Pop: read the top entry, its data lands next cycle.
              mem_raddr = top_idx;
              cnt_nxt   = cnt_dec;
              state_nxt = S_POP;
            end else if (next_frame_r >= end_frame_r) begin
              res_status_nxt = pfsa_pkg::ST_EXHAUSTED;
              state_nxt      = S_DONE;
            end else begin
              res_frame_nxt  = next_frame_r;
              res_status_nxt = pfsa_pkg::ST_ALLOCATED;
              next_frame_nxt = next_frame_r + pfsa_pkg::FRAME_BITS'(1);
              state_nxt      = S_DONE;
            end
          end else begin
            if (in_frame >= next_frame_r) begin
              res_status_nxt = pfsa_pkg::ST_NEVER;
              state_nxt      = S_DONE;
            end else if (cnt_r == '0) begin
              state_nxt = S_PUSH;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_POP: begin
        res_frame_nxt  = rd_data_r;
        res_status_nxt = pfsa_pkg::ST_ALLOCATED;
        state_nxt      = S_DONE;
      end
      S_SCAN: begin
        // Issue one read per cycle; compare the previous one.
        mem_raddr = idx_r;
        cmp_v_nxt = 1'b1;
        if (hit) begin
          res_status_nxt = pfsa_pkg::ST_DUPLICATE;
          state_nxt      = S_DONE;
        end else if (idx_r == top_idx) begin
          state_nxt = S_SCAN_TAIL;
        end else begin
          idx_nxt = idx_r + pfsa_pkg::IDX_W'(1);
        end
      end
      S_SCAN_TAIL: begin
        if (hit) begin
          res_status_nxt = pfsa_pkg::ST_DUPLICATE;
          state_nxt      = S_DONE;
        end else if (stack_full) begin
          res_status_nxt = pfsa_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        mem_we         = 1'b1;
        cnt_nxt        = cnt_r + pfsa_pkg::CNT_W'(1);
        res_status_nxt = pfsa_pkg::ST_FREED;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pfsa_pkg::OUT_DATA_W'({res_status_r, res_frame_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The user must write configuration only while the unit is idle; the unit does not enforce it.
    if (cfg_we) begin
      if (pfsa_pkg::reg_idx_t'(cfg_addr) == pfsa_pkg::REG_FIRST_FRAME) begin
        next_frame_nxt = cfg_wdata;
      end else begin
        end_frame_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      next_frame_r <= '0;
      end_frame_r  <= '0;
      cmp_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      next_frame_r <= next_frame_nxt;
      end_frame_r  <= end_frame_nxt;
      cmp_v_r      <= cmp_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    frame_r      <= frame_nxt;
    idx_r        <= idx_nxt;
    res_frame_r  <= res_frame_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= frame_r;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the page frame stack allocator unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfsa_pkg::*;

  // Largest frame number the unit can represent.
  localparam frame_t FRAME_MAX = '1;

  // One result word as the unit should present it.
  typedef struct packed {
    frame_t  frame;
    status_t status;
  } grant_t;

  // Tracks the allocator state as seen through accepted words. Every accepted
  // request yields exactly one result, so the expected results form a plain
  // FIFO. The list of frames currently handed out is also kept here, so the
  // stimulus can build free requests that make sense.
  class frame_ledger;
    frame_t      first_reg;
    frame_t      end_reg;
    frame_t      next_frame;
    frame_t      recycle[STACK_DEPTH];
    int unsigned recycle_count;
    frame_t      held[$];
    grant_t      pending_grants[$];
    int unsigned mismatches;

    function new();
      first_reg     = '0;
      end_reg       = '0;
      next_frame    = '0;
      recycle_count = 0;
      mismatches    = 0;
    endfunction

    // Writing first_frame also restarts the fresh-frame counter.
    function void load_register(reg_idx_t idx, frame_t value);
      if (idx == REG_FIRST_FRAME) begin
        first_reg  = value;
        next_frame = value;
      end else begin
        end_reg = value;
      end
    endfunction

    function void note_request(op_t op, frame_t frame);
      grant_t g;
      bit     stacked;
      int     found[$];
      g.frame = '0;
      if (op == OP_ALLOC) begin
        // Recycled frames go out first, newest first.
        if (recycle_count != 0) begin
          recycle_count--;
          g.frame  = recycle[recycle_count];
          g.status = ST_ALLOCATED;
        end else if (next_frame >= end_reg) begin
          // Also covers an inverted range: no counting up past end_frame.
          g.status = ST_EXHAUSTED;
        end else begin
          g.frame    = next_frame;
          next_frame = next_frame + 1'b1;
          g.status   = ST_ALLOCATED;
        end
        if (g.status == ST_ALLOCATED) held.push_back(g.frame);
      end else begin
        stacked = 1'b0;
        for (int i = 0; i < recycle_count; i++) begin
          if (recycle[i] == frame) stacked = 1'b1;
        end
        // Order matters: never issued, then duplicate, then full stack.
        if (frame >= next_frame) begin
          g.status = ST_NEVER;
        end else if (stacked) begin
          g.status = ST_DUPLICATE;
        end else if (recycle_count >= STACK_DEPTH) begin
          g.status = ST_FULL;
        end else begin
          recycle[recycle_count] = frame;
          recycle_count++;
          g.status = ST_FREED;
          found = held.find_first_index(x) with (x == frame);
          if (found.size() != 0) held.delete(found[0]);
        end
      end
      pending_grants.push_back(g);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_grant(logic [OUT_DATA_W-1:0] word);
      grant_t                want;
      frame_t                got_frame;
      logic [STATUS_W-1:0]   got_status;
      got_frame  = word[FRAME_BITS-1:0];
      got_status = word[FRAME_BITS +: STATUS_W];
      if (pending_grants.size() == 0) begin
        report_mismatch($sformatf("result word %h with no request outstanding", word));
        return;
      end
      want = pending_grants.pop_front();
      if (got_frame !== want.frame)
        report_mismatch($sformatf("frame_out %h, expected %h", got_frame, want.frame));
      if (got_status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                  got_status, want.status, want.status.name()));
      if ((word >> (FRAME_BITS + STATUS_W)) !== '0)
        report_mismatch($sformatf("padding bits not zero in word %h", word));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [43:0] frame_in, rest zero
  logic                  in_tuser   = 1'b0; // [0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [43:0] frame_out, [46:44] status, rest zero
  logic                  cfg_we     = 1'b0;
  logic                  cfg_addr   = 1'b0;
  frame_t                cfg_wdata  = '0;

  frame_ledger ledger = new();

  // Idle rates in percent per cycle, changed from phase to phase.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  // Set by the stimulus to ask for one long receiver hold-off.
  bit          hold_armed         = 1'b0;
  int unsigned stall_left         = 0;

  page_frame_stack_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Every result word accepted at a rising edge is checked against the oldest
  // expectation. Inputs change only through nonblocking updates at the edge,
  // so the values seen here are the ones the unit saw.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) ledger.check_grant(out_tdata);
  end

  // Result-side flow control. A requested hold-off keeps out_tready low for a
  // long stretch so the output register and the sequencer both fill up and
  // the unit has to push back on its input.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      stall_left = 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // A hang anywhere ends the run here.
  initial begin
    #2_000_000;
    $display("page_frame_stack_allocator_unit verification failed");
    $finish;
  end

  function automatic frame_t random_frame();
    return frame_t'({$urandom(), $urandom()});
  endfunction

  // Offers one request word and returns at the edge where it is accepted.
  // The valid line is only lowered for an idle gap, so back-to-back words
  // keep it high without a second update in the same time step.
  task automatic send_request(input op_t op, input frame_t frame);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'(frame);
    do @(posedge clk); while (!in_tready);
    ledger.note_request(op, frame);
  endtask

  // Stops offering words and waits until every expected result has come
  // back, plus a short margin, so that the unit is idle for register writes.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (ledger.pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input frame_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.load_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase under one register setting. Requests come in runs of
  // allocates or frees with a little noise of the other kind mixed in, so
  // the stack both drains to empty and fills to overflow. Frees most often name
  // frames that are handed out, some name stacked frames (duplicates), some lie
  // below the fresh counter, some at or just past it, and a few are fully random.
  task automatic random_phase(input bit load_first, input frame_t first_val,
                              input frame_t end_val, input int unsigned items,
                              input int unsigned send_pct, input int unsigned recv_pct,
                              input bit with_hold);
    int unsigned n;
    int unsigned run_left;
    int unsigned pick;
    bit          alloc_run;
    op_t         op;
    frame_t      frame;
    wait_for_results();
    if ($urandom_range(1) == 0) begin
      write_register(REG_END_FRAME, end_val);
      if (load_first) write_register(REG_FIRST_FRAME, first_val);
    end else begin
      if (load_first) write_register(REG_FIRST_FRAME, first_val);
      write_register(REG_END_FRAME, end_val);
    end
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    run_left  = 0;
    alloc_run = 1'b0;
    for (n = 0; n < items; n++) begin
      if (with_hold && n == items / 3) hold_armed = 1'b1;
      if (run_left == 0) begin
        alloc_run = $urandom_range(1);
        run_left  = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 80);
      end
      run_left--;
      op    = (alloc_run ^ ($urandom_range(9) == 0)) ? OP_ALLOC : OP_FREE;
      frame = random_frame();
      if (op == OP_FREE) begin
        pick = $urandom_range(99);
        if (pick < 50 && ledger.held.size() != 0)
          frame = ledger.held[$urandom_range(ledger.held.size() - 1)];
        else if (pick < 62 && ledger.recycle_count != 0)
          frame = ledger.recycle[$urandom_range(ledger.recycle_count - 1)];
        else if (pick < 75 && ledger.next_frame != 0)
          frame = frame % ledger.next_frame;
        else if (pick < 88)
          frame = ledger.next_frame + frame_t'($urandom_range(3));
      end
      send_request(op, frame);
    end
  endtask

  initial begin
    frame_t base;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling. Right after reset both registers are zero,
    // so an allocate finds the range exhausted and any free is unissued.
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);

    // A four-frame range: hand it all out, then run past its end.
    wait_for_results();
    write_register(REG_FIRST_FRAME, 44'd10);
    write_register(REG_END_FRAME, 44'd14);
    repeat (5) send_request(OP_ALLOC, '0);
    // Free, duplicate free, free at the fresh counter, and a free below the
    // start frame that was never handed out but still lies below the counter.
    send_request(OP_FREE, 44'd13);
    send_request(OP_FREE, 44'd13);
    send_request(OP_FREE, 44'd14);
    send_request(OP_FREE, 44'd2);
    // Recycled frames come back newest first, then the range is empty again.
    repeat (3) send_request(OP_ALLOC, '0);
    send_request(OP_FREE, FRAME_MAX);
    send_request(OP_ALLOC, FRAME_MAX);

    // Inverted range: start above end means exhausted at once, while frees
    // below the start frame are still taken and handed out again.
    wait_for_results();
    write_register(REG_FIRST_FRAME, 44'd100);
    write_register(REG_END_FRAME, 44'd50);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 44'd99);
    send_request(OP_ALLOC, '0);

    // The very top of the frame number space.
    wait_for_results();
    write_register(REG_FIRST_FRAME, FRAME_MAX - 2);
    write_register(REG_END_FRAME, FRAME_MAX);
    repeat (3) send_request(OP_ALLOC, '0);
    send_request(OP_FREE, FRAME_MAX - 1);
    send_request(OP_FREE, FRAME_MAX);

    // Fill the recycle stack to the brim and past it, with the receiver
    // stalling and one long hold-off while the sender keeps pushing.
    wait_for_results();
    write_register(REG_FIRST_FRAME, '0);
    write_register(REG_END_FRAME, 44'd4096);
    sender_idle_pct    = 0;
    receiver_stall_pct = 46;
    hold_armed         = 1'b1;
    repeat (72) send_request(OP_ALLOC, random_frame());
    while (ledger.recycle_count < STACK_DEPTH && ledger.held.size() != 0)
      send_request(OP_FREE, ledger.held[$urandom_range(ledger.held.size() - 1)]);
    repeat (3) begin
      if (ledger.held.size() != 0)
        send_request(OP_FREE, ledger.held[$urandom_range(ledger.held.size() - 1)]);
    end
    // Drain the whole stack and a little beyond into fresh frames.
    repeat (70) send_request(OP_ALLOC, random_frame());

    // Random phases across register settings and idle patterns. Each one
    // starts only once the previous results are all back.
    random_phase(1'b1, '0, 44'd200, 150, 0, 0, 1'b0);
    base = random_frame() >> 1;
    random_phase(1'b1, base, base + 44'd150, 150, 46, 0, 1'b0);
    // Only the end moves here, so the fresh counter carries on.
    random_phase(1'b0, '0, FRAME_MAX, 150, 0, 46, 1'b1);
    random_phase(1'b1, FRAME_MAX - 80, FRAME_MAX, 150, 25, 25, 1'b0);
    random_phase(1'b1, 44'd300, 44'd100, 150, 0, 0, 1'b0);
    random_phase(1'b1, random_frame(), '0, 150, 46, 0, 1'b0);
    random_phase(1'b1, FRAME_MAX, FRAME_MAX, 150, 0, 46, 1'b0);
    random_phase(1'b1, '0, FRAME_MAX, 150, 25, 25, 1'b1);

    // Everything back, then enough quiet cycles for the slowest free to
    // show any stray word.
    wait_for_results();
    repeat (80) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending_grants.size() == 0) begin
      $display("page_frame_stack_allocator_unit verification clean");
    end else begin
      $display("page_frame_stack_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
